[sv/sdida_pkg.sv]
// sdida_pkg: shared constants and types for the sticky device id allocator
// depends on nothing; used by the allocator top level

package sdida_pkg;

    // table size and derived widths
    localparam int NUM_SLOTS = 256;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int ID_W      = 8;
    localparam int OWNER_W   = 16;

    // request kinds carried in tuser
    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } req_type_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_INVALID = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OWN,
        ST_FREE,
        ST_RESP
    } state_t;

endpackage

[sv/sticky_device_id_allocator_unit.sv]
// sticky_device_id_allocator_unit: top level of the sticky device id allocator
// depends on sdida_pkg and sdida_ram

// The block takes one request at a time and takes no new request until the current
// result has been loaded into the output register. A release goes from idle straight
// to the response state. An allocate first walks the recorded slots through the owner
// ram, one slot per cycle, comparing each slot when its registered read returns,
// then, if no owner matched, walks the in-use bits of the recorded slots through the
// in-use ram the same way and claims the first free one, or the slot just past the
// recorded prefix when all of them are held, or reports full when every slot of the
// table is recorded and held. The single read port of each ram sets the speed of its
// walk. Recorded slots always form a prefix of the table and a slot in use is always
// recorded, so a fill count stands in for per-slot recorded bits and for the reset of
// the in-use ram, and no clearing pass is needed after reset.

module sticky_device_id_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // bus_num[7:0], dev_num[12:8], fun_num[15:13], release_id[23:16]
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // granted_id[7:0], status[9:8], reused[10], zero fill
);

    localparam int SLOT_W  = sdida_pkg::SLOT_W;
    localparam int CNT_W   = sdida_pkg::CNT_W;
    localparam int ID_W    = sdida_pkg::ID_W;
    localparam int OWNER_W = sdida_pkg::OWNER_W;

    sdida_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [CNT_W-1:0]   rec_count_reg, rec_count_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [OWNER_W-1:0] who_reg, who_next;

    logic [ID_W-1:0]    res_id_reg, res_id_next;
    sdida_pkg::status_t res_status_reg, res_status_next;
    logic               res_reused_reg, res_reused_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    sdida_pkg::status_t out_status_reg, out_status_next;
    logic               out_reused_reg, out_reused_next;

    logic               use_wr_en, use_wr_data, use_rd_en, use_rd_data;
    logic [SLOT_W-1:0]  use_wr_addr;
    logic               ram_wr_en, ram_rd_en;
    logic [SLOT_W-1:0]  ram_wr_addr;
    logic [SLOT_W-1:0]  ram_rd_addr;
    logic [OWNER_W-1:0] ram_rd_data;

    logic [ID_W-1:0]    in_release_id;
    logic [OWNER_W-1:0] in_owner;

    // input field unpacking; owner key is {bus, dev, fun}
    assign in_owner      = {s_tdata[7:0], s_tdata[12:8], s_tdata[15:13]};
    assign in_release_id = s_tdata[23:16];

    // owner record store
    sdida_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (sdida_pkg::NUM_SLOTS)
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (who_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // in-use bit store; entries past the recorded prefix are never read and count as free
    sdida_ram #(
        .WIDTH (1),
        .DEPTH (sdida_pkg::NUM_SLOTS)
    ) u_use_ram (
        .clk     (clk),
        .wr_en   (use_wr_en),
        .wr_addr (use_wr_addr),
        .wr_data (use_wr_data),
        .rd_en   (use_rd_en),
        .rd_addr (scan_reg[SLOT_W-1:0]),
        .rd_data (use_rd_data)
    );

    // sequencer next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        rec_count_next  = rec_count_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        who_next        = who_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        res_reused_next = res_reused_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;
        out_reused_next = out_reused_reg;
        use_wr_en       = 1'b0;
        use_wr_addr     = cmp_idx_reg;
        use_wr_data     = 1'b0;
        use_rd_en       = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = cmp_idx_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = scan_reg[SLOT_W-1:0];
        s_tready        = 1'b0;

        // output register drains on transfer
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            sdida_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    res_id_next     = '0;
                    res_reused_next = 1'b0;
                    res_status_next = sdida_pkg::STAT_OK;
                    if (s_tuser == sdida_pkg::REQ_RELEASE)
                    begin
                        if ({1'b0, in_release_id} >= (ID_W+1)'(sdida_pkg::NUM_SLOTS))
                        begin
                            res_status_next = sdida_pkg::STAT_INVALID;
                        end
                        else
                        begin
                            use_wr_en   = 1'b1;
                            use_wr_addr = in_release_id[SLOT_W-1:0];
                            use_wr_data = 1'b0;
                        end
                        state_next = sdida_pkg::ST_RESP;
                    end
                    else
                    begin
                        who_next       = in_owner;
                        scan_next      = '0;
                        cmp_valid_next = 1'b0;
                        state_next     = sdida_pkg::ST_OWN;
                    end
                end
            end

            sdida_pkg::ST_OWN:
            begin
                // compare the slot read last cycle while the next one is read
                if (cmp_valid_reg && ram_rd_data == who_reg)
                begin
                    use_wr_en       = 1'b1;
                    use_wr_addr     = cmp_idx_reg;
                    use_wr_data     = 1'b1;
                    res_id_next     = ID_W'(cmp_idx_reg);
                    res_reused_next = 1'b1;
                    state_next      = sdida_pkg::ST_RESP;
                end
                else if (scan_reg < rec_count_reg)
                begin
                    ram_rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[SLOT_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                end
                else if (cmp_valid_reg)
                begin
                    cmp_valid_next = 1'b0;
                end
                else
                begin
                    scan_next  = '0;
                    state_next = sdida_pkg::ST_FREE;
                end
            end

            sdida_pkg::ST_FREE:
            begin
                // first recorded slot not in use is claimed
                if (cmp_valid_reg && !use_rd_data)
                begin
                    use_wr_en   = 1'b1;
                    use_wr_addr = cmp_idx_reg;
                    use_wr_data = 1'b1;
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = cmp_idx_reg;
                    res_id_next = ID_W'(cmp_idx_reg);
                    state_next  = sdida_pkg::ST_RESP;
                end
                else if (scan_reg < rec_count_reg)
                begin
                    use_rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[SLOT_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                end
                else if (rec_count_reg == CNT_W'(sdida_pkg::NUM_SLOTS))
                begin
                    res_status_next = sdida_pkg::STAT_FULL;
                    state_next      = sdida_pkg::ST_RESP;
                end
                else
                begin
                    // every recorded slot is held, claim the one past the prefix
                    use_wr_en      = 1'b1;
                    use_wr_addr    = rec_count_reg[SLOT_W-1:0];
                    use_wr_data    = 1'b1;
                    ram_wr_en      = 1'b1;
                    ram_wr_addr    = rec_count_reg[SLOT_W-1:0];
                    res_id_next    = ID_W'(rec_count_reg[SLOT_W-1:0]);
                    rec_count_next = rec_count_reg + 1'b1;
                    state_next     = sdida_pkg::ST_RESP;
                end
            end

            sdida_pkg::ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_id_next     = res_id_reg;
                    out_status_next = res_status_reg;
                    out_reused_next = res_reused_reg;
                    state_next      = sdida_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sdida_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdida_pkg::ST_IDLE;
            scan_reg      <= '0;
            rec_count_reg <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            rec_count_reg <= rec_count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        who_reg        <= who_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        res_reused_reg <= res_reused_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
        out_reused_reg <= out_reused_next;
    end

    // result packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_reused_reg, out_status_reg, out_id_reg};

    // fill count never passes the table size
    a_rec_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rec_count_reg <= CNT_W'(sdida_pkg::NUM_SLOTS))
        else $error("recorded slot count past table size");

    // a claimed slot lies inside or just past the recorded prefix
    a_claim_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdida_pkg::ST_FREE && ram_wr_en) |-> {1'b0, ram_wr_addr} <= rec_count_reg)
        else $error("claimed slot beyond recorded prefix");

    // a valid release clears the in-use bit of its slot
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == sdida_pkg::REQ_RELEASE)
        |-> (use_wr_en && !use_wr_data))
        else $error("release did not clear the in-use bit");

    // reuse flag only with an ok status
    a_reused_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[10]) |-> m_tdata[9:8] == sdida_pkg::STAT_OK)
        else $error("reused result without ok status");

    // a result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("pending result overwritten");

endmodule

[sv/sdida_ram.sv]
// sdida_ram: generic single write port, single read port ram
// registered read data; no dependencies

module sdida_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[bench/tb.sv]
// tb: self-checking bench for sticky_device_id_allocator_unit, stream in, stream out
// depends on sdida_pkg and the allocator rtl; predicts every grant with its own slot table

`timescale 1ns / 1ps

module tb;

    // one request as it goes over the slave side
    typedef struct packed {
        sdida_pkg::req_type_t kind;
        logic [7:0]           bus;
        logic [4:0]           dev;
        logic [2:0]           fun;
        logic [7:0]           rel_id;
    } id_req_t;

    // one grant as it comes back on the master side
    typedef struct packed {
        logic [sdida_pkg::ID_W-1:0] id;
        sdida_pkg::status_t         status;
        logic                       reused;
    } grant_t;

    // directed row, with a typed grant where it is obvious
    typedef struct packed {
        id_req_t req;
        logic    typed;
        grant_t  grant;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // bus_num[7:0], dev_num[12:8], fun_num[15:13], release_id[23:16]
    logic        s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // granted_id[7:0], status[9:8], reused[10], zero fill

    // predictor copy of the slot table
    logic                          slot_held [sdida_pkg::NUM_SLOTS];
    logic                          slot_known[sdida_pkg::NUM_SLOTS];
    logic [sdida_pkg::OWNER_W-1:0] slot_owner[sdida_pkg::NUM_SLOTS];

    grant_t       grants_due[$];
    dir_row_t     dir_rows[$];
    logic [15:0]  owner_pool[24];
    int unsigned  fails = 0;
    bit           idle_en = 1'b1;

    sticky_device_id_allocator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // grant prediction: sticky owner search, then lowest free slot
    function automatic grant_t predict_grant(input id_req_t r);
        grant_t                        g;
        logic [sdida_pkg::OWNER_W-1:0] who;
        who = {r.bus, r.dev, r.fun};
        g.id = '0;
        g.status = sdida_pkg::STAT_OK;
        g.reused = 1'b0;
        if (r.kind == sdida_pkg::REQ_RELEASE)
        begin
            if (int'(r.rel_id) >= sdida_pkg::NUM_SLOTS)
                g.status = sdida_pkg::STAT_INVALID;
            else
                slot_held[r.rel_id] = 1'b0;
            return g;
        end
        // recorded slots form a prefix, stop at the first unrecorded one
        for (int i = 0; i < sdida_pkg::NUM_SLOTS; i++)
        begin
            if (!slot_known[i])
                break;
            if (slot_owner[i] == who)
            begin
                slot_held[i] = 1'b1;
                g.id = sdida_pkg::ID_W'(i);
                g.reused = 1'b1;
                return g;
            end
        end
        // claim the lowest free slot, overwriting any old owner
        for (int i = 0; i < sdida_pkg::NUM_SLOTS; i++)
        begin
            if (!slot_held[i])
            begin
                slot_held[i] = 1'b1;
                slot_known[i] = 1'b1;
                slot_owner[i] = who;
                g.id = sdida_pkg::ID_W'(i);
                return g;
            end
        end
        g.status = sdida_pkg::STAT_FULL;
        return g;
    endfunction

    function automatic dir_row_t row(input sdida_pkg::req_type_t k, input logic [7:0] b,
                                     input logic [4:0] d, input logic [2:0] f,
                                     input logic [7:0] rel, input logic typed,
                                     input logic [7:0] id, input sdida_pkg::status_t st,
                                     input logic re);
        dir_row_t x;
        x.req.kind = k;
        x.req.bus = b;
        x.req.dev = d;
        x.req.fun = f;
        x.req.rel_id = rel;
        x.typed = typed;
        x.grant.id = id;
        x.grant.status = st;
        x.grant.reused = re;
        return x;
    endfunction

    // random request, shaped by the phase of the run
    function automatic id_req_t random_req(input int k);
        id_req_t     r;
        int unsigned pick;
        logic [15:0] who;
        pick = $urandom_range(0, 99);
        who = owner_pool[$urandom_range(0, 23)];
        r.rel_id = 8'($urandom_range(0, 255));
        r.kind = sdida_pkg::REQ_ALLOC;
        if (k < 700)
        begin
            // warm-up around a small set of requesters and low slots
            if (pick >= 55 && pick < 65)
                who = 16'($urandom);
            else if (pick >= 65)
            begin
                r.kind = sdida_pkg::REQ_RELEASE;
                who = 16'($urandom);
                if (pick < 95)
                    r.rel_id = 8'($urandom_range(0, 31));
            end
        end
        else if (k < 1050)
        begin
            // fill the table with fresh owners, then keep hitting it full
            if (pick < 90)
                who = 16'($urandom);
        end
        else if (k < 1200)
        begin
            // drain
            if (pick < 80)
            begin
                r.kind = sdida_pkg::REQ_RELEASE;
                who = 16'($urandom);
            end
            else if (pick < 90)
                who = 16'($urandom);
        end
        else
        begin
            if (pick >= 45 && pick < 60)
                who = 16'($urandom);
            else if (pick >= 60)
            begin
                r.kind = sdida_pkg::REQ_RELEASE;
                who = 16'($urandom);
            end
        end
        {r.bus, r.dev, r.fun} = who;
        return r;
    endfunction

    // one slave-side transfer, then an optional gap
    task automatic send_req(input id_req_t r, input logic typed, input grant_t given);
        grant_t model;
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {r.rel_id, r.fun, r.dev, r.bus};
        do
            @(posedge clk);
        while (!s_tready);
        model = predict_grant(r);
        grants_due.push_back(typed ? given : model);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // master-side ready with random stall bursts
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest expected grant
    initial
    begin : grant_check
        grant_t got;
        grant_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.id = m_tdata[7:0];
                got.status = sdida_pkg::status_t'(m_tdata[9:8]);
                got.reused = m_tdata[10];
                if (grants_due.size() == 0)
                begin
                    $error("result with no request pending: %h", m_tdata);
                    fails++;
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (got.id !== want.id)
                    begin
                        $error("granted_id expected %0d got %0d", want.id, got.id);
                        fails++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.reused !== want.reused)
                    begin
                        $error("reused expected %0d got %0d", want.reused, got.reused);
                        fails++;
                    end
                end
            end
        end
    end

    // main sequence
    initial
    begin
        grant_t no_grant;
        no_grant = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= sdida_pkg::REQ_ALLOC;
        s_tdata  <= '0;
        for (int i = 0; i < sdida_pkg::NUM_SLOTS; i++)
        begin
            slot_held[i] = 1'b0;
            slot_known[i] = 1'b0;
            slot_owner[i] = '0;
        end
        owner_pool[0] = 16'h0000;
        owner_pool[1] = 16'hFFFF;
        for (int i = 2; i < 24; i++)
            owner_pool[i] = 16'($urandom);

        // directed part: zero owner, sticky reuse, reclaim of a recorded slot
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'h00, 5'h00, 3'h0, 8'h00, 1'b1,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'h00, 5'h00, 3'h0, 8'hFF, 1'b1,
                               8'd0, sdida_pkg::STAT_OK, 1'b1));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'hFF, 5'h1F, 3'h7, 8'h00, 1'b1,
                               8'd1, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_RELEASE, 8'hFF, 5'h1F, 3'h7, 8'h00, 1'b1,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'hFF, 5'h1F, 3'h7, 8'hFF, 1'b1,
                               8'd1, sdida_pkg::STAT_OK, 1'b1));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'h00, 5'h00, 3'h0, 8'h00, 1'b1,
                               8'd0, sdida_pkg::STAT_OK, 1'b1));
        dir_rows.push_back(row(sdida_pkg::REQ_RELEASE, 8'h00, 5'h00, 3'h0, 8'hFF, 1'b1,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_RELEASE, 8'h5A, 5'h15, 3'h2, 8'h01, 1'b1,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'h12, 5'h05, 3'h3, 8'h00, 1'b1,
                               8'd1, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'hFF, 5'h1F, 3'h7, 8'h00, 1'b1,
                               8'd2, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'h12, 5'h05, 3'h3, 8'h00, 1'b1,
                               8'd1, sdida_pkg::STAT_OK, 1'b1));
        dir_rows.push_back(row(sdida_pkg::REQ_RELEASE, 8'h00, 5'h00, 3'h0, 8'h02, 1'b1,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'h80, 5'h10, 3'h4, 8'h80, 1'b0,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'hFF, 5'h00, 3'h7, 8'h7F, 1'b0,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'h00, 5'h1F, 3'h0, 8'hAA, 1'b0,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'h01, 5'h01, 3'h1, 8'h55, 1'b0,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_RELEASE, 8'hA5, 5'h0A, 3'h5, 8'h03, 1'b0,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_RELEASE, 8'h3C, 5'h13, 3'h6, 8'h80, 1'b0,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'hFF, 5'h1F, 3'h7, 8'h01, 1'b0,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));
        dir_rows.push_back(row(sdida_pkg::REQ_ALLOC,   8'h80, 5'h10, 3'h4, 8'hFE, 1'b0,
                               8'd0, sdida_pkg::STAT_OK, 1'b0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].grant);

        // random part, calm stretches and a calm tail
        for (int k = 0; k < 1930; k++)
        begin
            idle_en = (k < 1700) && ((k / 120) % 4 != 3);
            send_req(random_req(k), 1'b0, no_grant);
        end
        s_tvalid <= 1'b0;

        wait (grants_due.size() == 0);
        repeat (600) @(posedge clk);
        if (fails == 0 && grants_due.size() == 0)
            $display("sticky_device_id_allocator_unit verification clean");
        else
            $display("sticky_device_id_allocator_unit verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("sticky_device_id_allocator_unit verification failed");
        $finish;
    end

endmodule
